// ----- rtl/core/scvm_pkg.sv -----
// shared types and constants of the sample clip voice mixer
package scvm_pkg;

  localparam logic [2:0] OP_LOAD   = 3'd0;
  localparam logic [2:0] OP_MUSIC  = 3'd1;
  localparam logic [2:0] OP_EFFECT = 3'd2;
  localparam logic [2:0] OP_CTRL   = 3'd3;
  localparam logic [2:0] OP_LOOP   = 3'd4;
  localparam logic [2:0] OP_TICK   = 3'd5;

  localparam logic [16:0] CLIP_MAX  = 17'd65536;
  localparam logic [7:0]  VOL_RESET = 8'd128;
  // ceil of 2^31 / 255, exact floor division for magnitudes below 2^24
  localparam logic [23:0] RECIP_255 = 24'd8421505;

  localparam logic REG_MUSIC_VOLUME  = 1'b0;
  localparam logic REG_EFFECT_VOLUME = 1'b1;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        mem_addr;
    logic signed [15:0] sample_value;
    logic [15:0]        clip_start;
    logic [16:0]        clip_len;
    logic [16:0]        loop_point;
    logic [23:0]        phase_step;
    logic [15:0]        track_id;
    logic               loop_enable;
    logic               pause_music;
    logic               stop_music;
    logic               clear_effects;
  } cmd_t;

endpackage

// ----- rtl/core/scvm_if.sv -----
// item channels of the sample clip voice mixer
interface scvm_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic [15:0]        mem_addr;
  logic signed [15:0] sample_value;
  logic [15:0]        clip_start;
  logic [16:0]        clip_length;
  logic [15:0]        loop_start;
  logic [23:0]        phase_step;
  logic [15:0]        track_id;
  logic               loop_enable;
  logic               pause_music;
  logic               stop_music;
  logic               clear_effects;

  modport source (
    output valid, opcode, mem_addr, sample_value, clip_start, clip_length, loop_start,
           phase_step, track_id, loop_enable, pause_music, stop_music, clear_effects,
    input  ready
  );
  modport sink (
    input  valid, opcode, mem_addr, sample_value, clip_start, clip_length, loop_start,
           phase_step, track_id, loop_enable, pause_music, stop_music, clear_effects,
    output ready
  );
endinterface

interface scvm_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mixed_sample;
  logic               music_playing;
  logic               effects_active;
  logic               start_rejected;

  modport source (
    output valid, mixed_sample, music_playing, effects_active, start_rejected,
    input  ready
  );
  modport sink (
    input  valid, mixed_sample, music_playing, effects_active, start_rejected,
    output ready
  );
endinterface

// ----- rtl/core/sample_clip_voice_mixer_top.sv -----
// top level of the sample clip voice mixer
//
// cmd carries one operation per item (load sample, start music, start
// effect, control, set loop option, tick); res returns exactly one item per
// command with the mix on a tick and the voice status after the operation.
// volumes are written over the apb port: paddr bit 2 clear music, set effects.
// a two-entry command queue decouples cmd from the execution sequencer, so
// items are taken while a result waits in the output register.
// a tick walks every voice in turn: idle voices are skipped, a playing voice
// takes two registered sample memory reads, each behind the address wrap
// states (quotient, then correction), then interpolate, volume and
// accumulate steps, plus a bit-serial modulo unit when the music loop
// wraps; the sequencer is shared by all voices.
// reset stops every voice, sets both volumes to 128 and empties the queue;
// sample memory is not cleared and must be loaded before it is played.
// when res stalls the result is held and cmd fills the queue, then stalls.
module sample_clip_voice_mixer_top
  import scvm_pkg::*;
#(
  parameter int SAMPLE_MEM_DEPTH = 65536,
  parameter int SFX_VOICES       = 4,
  parameter int PHASE_FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  scvm_cmd_if.sink    cmd,
  scvm_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] music_volume;
  logic [7:0] effect_volume;
  logic       q_valid;
  cmd_t       q_cmd;
  logic       q_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_EFFECT_VOLUME) ? {24'd0, effect_volume}
                                                  : {24'd0, music_volume};

  always_ff @(posedge clk) begin
    if (rst) begin
      music_volume  <= VOL_RESET;
      effect_volume <= VOL_RESET;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_EFFECT_VOLUME) begin
        effect_volume <= pwdata[7:0];
      end else begin
        music_volume <= pwdata[7:0];
      end
    end
  end

  scvm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  scvm_back #(
    .SAMPLE_MEM_DEPTH (SAMPLE_MEM_DEPTH),
    .SFX_VOICES       (SFX_VOICES),
    .PHASE_FRAC_BITS  (PHASE_FRAC_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop),
    .music_volume  (music_volume),
    .effect_volume (effect_volume),
    .res           (res)
  );

endmodule

// ----- rtl/core/scvm_ram.sv -----
// generic single write port ram with registered read
module scvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/scvm_front.sv -----
// input side: accepts items, normalizes lengths and queues commands
module scvm_front
  import scvm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  scvm_cmd_if.sink   cmd,
  output logic       q_valid,
  output cmd_t       q_cmd,
  input  logic       q_pop
);

  cmd_t       fifo [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  cmd_t       in_cmd;
  logic [16:0] len_sat;
  logic [16:0] lstart;

  assign cmd.ready = (count != 2'd2);
  assign push      = cmd.valid && cmd.ready;
  assign q_valid   = (count != 2'd0);
  assign q_cmd     = fifo[rd_ptr];

  // oversized lengths saturate, loop point clamps to the length
  always_comb begin
    len_sat = (cmd.clip_length > CLIP_MAX) ? CLIP_MAX : cmd.clip_length;
    lstart  = {1'b0, cmd.loop_start};
    in_cmd.opcode        = cmd.opcode;
    in_cmd.mem_addr      = cmd.mem_addr;
    in_cmd.sample_value  = cmd.sample_value;
    in_cmd.clip_start    = cmd.clip_start;
    in_cmd.clip_len      = len_sat;
    in_cmd.loop_point    = (lstart < len_sat) ? lstart : len_sat;
    in_cmd.phase_step    = cmd.phase_step;
    in_cmd.track_id      = cmd.track_id;
    in_cmd.loop_enable   = cmd.loop_enable;
    in_cmd.pause_music   = cmd.pause_music;
    in_cmd.stop_music    = cmd.stop_music;
    in_cmd.clear_effects = cmd.clear_effects;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wr_ptr] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/scvm_back.sv -----
// execution side: voice state, sample memory, interpolation and mixing
module scvm_back
  import scvm_pkg::*;
#(
  parameter int SAMPLE_MEM_DEPTH = 65536,
  parameter int SFX_VOICES       = 4,
  parameter int PHASE_FRAC_BITS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  cmd_t       q_cmd,
  output logic       q_pop,
  input  logic [7:0] music_volume,
  input  logic [7:0] effect_volume,
  scvm_res_if.source res
);

  localparam int P  = PHASE_FRAC_BITS;
  localparam int PW = 17 + P;
  localparam int AW = $clog2(SAMPLE_MEM_DEPTH);
  localparam int VW = $clog2(SFX_VOICES + 2);
  localparam int EW = (SFX_VOICES > 1) ? $clog2(SFX_VOICES) : 1;
  localparam bit NEED_WRAP = (SAMPLE_MEM_DEPTH < 131072);
  localparam logic [24:0] ADDR_D     = 25'(SAMPLE_MEM_DEPTH);
  localparam logic [24:0] ADDR_RECIP = 25'((64'd1 << 34) / SAMPLE_MEM_DEPTH);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_VSEL = 4'd1;
  localparam logic [3:0] ST_AQ   = 4'd2;
  localparam logic [3:0] ST_AR   = 4'd3;
  localparam logic [3:0] ST_RD   = 4'd4;
  localparam logic [3:0] ST_INT  = 4'd5;
  localparam logic [3:0] ST_MUL  = 4'd6;
  localparam logic [3:0] ST_SCL  = 4'd7;
  localparam logic [3:0] ST_ACC  = 4'd8;
  localparam logic [3:0] ST_MOD  = 4'd9;
  localparam logic [3:0] ST_SAT  = 4'd10;

  logic [3:0] state;
  cmd_t       cur;

  // voice state
  logic          music_active;
  logic          music_paused;
  logic [15:0]   music_track;
  logic [15:0]   music_base;
  logic [16:0]   music_length;
  logic [16:0]   music_loop_point;
  logic          music_looping;
  logic [PW-1:0] music_phase;
  logic [23:0]   music_increment;
  logic          loop_option;
  logic [SFX_VOICES-1:0] effect_valid;
  logic [15:0]   effect_base      [SFX_VOICES];
  logic [16:0]   effect_length    [SFX_VOICES];
  logic [PW-1:0] effect_phase     [SFX_VOICES];
  logic [23:0]   effect_increment [SFX_VOICES];

  // result register
  logic               res_valid;
  logic signed [15:0] res_sample;
  logic               res_play;
  logic               res_fx;
  logic               res_rej;

  // working registers of the voice in progress
  logic [VW-1:0]      vidx;
  logic [15:0]        w_base;
  logic [16:0]        w_len;
  logic [PW-1:0]      w_phase;
  logic [23:0]        w_inc;
  logic               w_loop;
  logic [16:0]        w_lp;
  logic [7:0]         w_vol;
  logic [16:0]        nxt_idx;
  logic [P-1:0]       frac;
  logic               second;
  logic               is_load;
  logic [16:0]        addr_x;
  logic [7:0]         addr_q;
  logic signed [15:0] cur_s;
  logic signed [15:0] nxt_s;
  logic signed [17+P:0] prod;
  logic signed [25:0] vprod;
  logic [PW-1:0]      new_phase;
  logic [47:0]        mq;
  logic               neg;
  logic signed [21:0] mix_acc;
  logic [16:0]        mod_div;
  logic [16:0]        mod_d;
  logic [16:0]        mod_rem;
  logic [4:0]         mod_cnt;

  // memory
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [15:0]   ram_rdata;
  logic [32:0]   addr_r;

  scvm_ram #(.WIDTH(16), .DEPTH(SAMPLE_MEM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (cur.sample_value),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  assign ram_we = (state == ST_AR) && is_load;

  // address modulo depth: reciprocal quotient, then one correction
  always_comb begin
    addr_r = 33'(addr_x) - 33'(addr_q) * 33'(ADDR_D);
    if (addr_r >= 33'(ADDR_D)) begin
      addr_r = addr_r - 33'(ADDR_D);
    end
    ram_addr = NEED_WRAP ? AW'(addr_r) : AW'(addr_x);
  end

  logic [41:0] addr_prod;
  assign addr_prod = 42'(addr_x) * 42'(ADDR_RECIP);

  // command decode for the operations answered straight from the idle state
  logic          slot_found;
  logic [EW-1:0] slot;
  logic          same_track;
  logic          op_play;
  logic          op_fx;
  logic          op_rej;

  always_comb begin
    slot_found = 1'b0;
    slot       = '0;
    for (int i = SFX_VOICES - 1; i >= 0; i--) begin
      if (!effect_valid[i]) begin
        slot_found = 1'b1;
        slot       = EW'(i);
      end
    end
  end

  always_comb begin
    same_track = music_active && (music_track == q_cmd.track_id);
    op_play    = music_active && !music_paused;
    op_fx      = |effect_valid;
    op_rej     = 1'b0;
    case (q_cmd.opcode)
      OP_MUSIC: begin
        if (same_track) begin
          op_play = 1'b1;
        end else if (q_cmd.clip_len == 17'd0) begin
          op_rej = 1'b1;
        end else begin
          op_play = 1'b1;
        end
      end
      OP_EFFECT: begin
        op_rej = (q_cmd.clip_len == 17'd0) || !slot_found;
        op_fx  = (|effect_valid) || !op_rej;
      end
      OP_CTRL: begin
        op_play = music_active && !q_cmd.stop_music && !q_cmd.pause_music;
        op_fx   = q_cmd.clear_effects ? 1'b0 : (|effect_valid);
      end
      default: begin
      end
    endcase
  end

  // selected voice at the start of its tick
  logic [EW-1:0] eidx;
  logic          sel_run;
  logic [15:0]   sel_base;
  logic [16:0]   sel_len;
  logic [PW-1:0] sel_phase;
  logic [23:0]   sel_inc;
  logic          sel_loop;
  logic [16:0]   sel_lp;
  logic [7:0]    sel_vol;
  logic [15:0]   sel_idx;
  logic [16:0]   sel_nxt;

  assign eidx = EW'(vidx - VW'(1));

  always_comb begin
    if (vidx == '0) begin
      sel_run   = music_active && !music_paused;
      sel_base  = music_base;
      sel_len   = music_length;
      sel_phase = music_phase;
      sel_inc   = music_increment;
      sel_loop  = music_looping;
      sel_lp    = music_loop_point;
      sel_vol   = music_volume;
    end else begin
      sel_run   = effect_valid[eidx];
      sel_base  = effect_base[eidx];
      sel_len   = effect_length[eidx];
      sel_phase = effect_phase[eidx];
      sel_inc   = effect_increment[eidx];
      sel_loop  = 1'b0;
      sel_lp    = 17'd0;
      sel_vol   = effect_volume;
    end
    sel_idx = sel_phase[P+15:P];
    sel_nxt = ((17'(sel_idx) + 17'd1) < (sel_len - 17'd1)) ?
              (17'(sel_idx) + 17'd1) : (sel_len - 17'd1);
  end

  // datapath combinational pieces
  logic signed [16:0]   diff;
  logic signed [17+P:0] prod_b;
  logic signed [16:0]   interp;
  logic [25:0]          mag;
  logic [16:0]          quo;
  logic signed [21:0]   scaled;
  logic [PW-1:0]        end_fx;
  logic [16:0]          ls;
  logic [PW-1:0]        ls_fx;
  logic [PW-1:0]        from_ls;
  logic                 can_wrap;
  logic [17:0]          rem2;
  logic [16:0]          rem_next;
  logic [PW-1:0]        wrapped;

  always_comb begin
    diff    = 17'(nxt_s) - 17'(cur_s);
    prod_b  = prod[17+P] ? (prod + (18+P)'((1 << P) - 1)) : prod;
    interp  = 17'(cur_s) + prod_b[16+P:P];
    mag     = vprod[25] ? 26'(-vprod) : 26'(vprod);
    quo     = mq[47:31];
    scaled  = neg ? -$signed({5'b0, quo}) : $signed({5'b0, quo});
    end_fx  = {w_len, {P{1'b0}}};
    ls      = (w_lp < (w_len - 17'd1)) ? w_lp : (w_len - 17'd1);
    ls_fx   = {ls, {P{1'b0}}};
    from_ls = new_phase - ls_fx;
    can_wrap = w_loop && (w_len > 17'd1) && (ls < (w_len - 17'd1));
    rem2    = {mod_rem, mod_div[16]};
    if (rem2 >= {1'b0, mod_d}) begin
      rem2 = rem2 - {1'b0, mod_d};
    end
    rem_next = rem2[16:0];
    wrapped  = {w_lp, {P{1'b0}}} + {rem_next, new_phase[P-1:0]};
  end

  assign q_pop = (state == ST_IDLE) && q_valid && !res_valid;

  assign res.valid          = res_valid;
  assign res.mixed_sample   = res_sample;
  assign res.music_playing  = res_play;
  assign res.effects_active = res_fx;
  assign res.start_rejected = res_rej;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      res_valid        <= 1'b0;
      music_active     <= 1'b0;
      music_paused     <= 1'b0;
      music_track      <= 16'd0;
      music_base       <= 16'd0;
      music_length     <= 17'd0;
      music_loop_point <= 17'd0;
      music_looping    <= 1'b0;
      music_phase      <= '0;
      music_increment  <= 24'd0;
      loop_option      <= 1'b0;
      effect_valid     <= '0;
      vidx             <= '0;
    end else begin
      if (res_valid && res.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_pop) begin
            cur <= q_cmd;
            case (q_cmd.opcode)
              OP_LOAD: begin
                is_load <= 1'b1;
                addr_x  <= 17'(q_cmd.mem_addr);
                state   <= ST_AQ;
              end
              OP_TICK: begin
                is_load <= 1'b0;
                vidx    <= '0;
                mix_acc <= '0;
                state   <= ST_VSEL;
              end
              default: begin
                case (q_cmd.opcode)
                  OP_MUSIC: begin
                    if (same_track) begin
                      music_paused <= 1'b0;
                    end else if (q_cmd.clip_len != 17'd0) begin
                      music_base       <= q_cmd.clip_start;
                      music_length     <= q_cmd.clip_len;
                      music_loop_point <= q_cmd.loop_point;
                      music_looping    <= loop_option;
                      music_phase      <= '0;
                      music_increment  <= q_cmd.phase_step;
                      music_track      <= q_cmd.track_id;
                      music_active     <= 1'b1;
                      music_paused     <= 1'b0;
                    end
                  end
                  OP_EFFECT: begin
                    if (!op_rej) begin
                      effect_valid[slot]     <= 1'b1;
                      effect_base[slot]      <= q_cmd.clip_start;
                      effect_length[slot]    <= q_cmd.clip_len;
                      effect_phase[slot]     <= '0;
                      effect_increment[slot] <= q_cmd.phase_step;
                    end
                  end
                  OP_CTRL: begin
                    music_paused <= q_cmd.pause_music;
                    if (q_cmd.stop_music) begin
                      music_active <= 1'b0;
                      music_track  <= 16'd0;
                    end
                    if (q_cmd.clear_effects) begin
                      effect_valid <= '0;
                    end
                  end
                  OP_LOOP: begin
                    loop_option <= q_cmd.loop_enable;
                    if (music_active) begin
                      music_looping <= q_cmd.loop_enable;
                    end
                  end
                  default: begin
                  end
                endcase
                res_valid  <= 1'b1;
                res_sample <= 16'sd0;
                res_play   <= op_play;
                res_fx     <= op_fx;
                res_rej    <= op_rej;
              end
            endcase
          end
        end
        ST_VSEL: begin
          if (vidx == VW'(SFX_VOICES + 1)) begin
            state <= ST_SAT;
          end else if (!sel_run) begin
            vidx <= vidx + VW'(1);
          end else begin
            w_base  <= sel_base;
            w_len   <= sel_len;
            w_phase <= sel_phase;
            w_inc   <= sel_inc;
            w_loop  <= sel_loop;
            w_lp    <= sel_lp;
            w_vol   <= sel_vol;
            nxt_idx <= sel_nxt;
            frac    <= sel_phase[P-1:0];
            addr_x  <= 17'(sel_base) + 17'(sel_idx);
            second  <= 1'b0;
            state   <= ST_AQ;
          end
        end
        ST_AQ: begin
          addr_q <= addr_prod[41:34];
          state  <= ST_AR;
        end
        ST_AR: begin
          if (is_load) begin
            res_valid  <= 1'b1;
            res_sample <= 16'sd0;
            res_play   <= music_active && !music_paused;
            res_fx     <= |effect_valid;
            res_rej    <= 1'b0;
            state      <= ST_IDLE;
          end else begin
            state <= ST_RD;
          end
        end
        ST_RD: begin
          if (!second) begin
            cur_s  <= $signed(ram_rdata);
            addr_x <= 17'(w_base) + nxt_idx;
            second <= 1'b1;
            state  <= ST_AQ;
          end else begin
            nxt_s <= $signed(ram_rdata);
            state <= ST_INT;
          end
        end
        ST_INT: begin
          prod      <= diff * $signed({1'b0, frac});
          new_phase <= w_phase + PW'(w_inc);
          state     <= ST_MUL;
        end
        ST_MUL: begin
          vprod <= interp * $signed({1'b0, w_vol});
          state <= ST_SCL;
        end
        ST_SCL: begin
          mq    <= 48'(mag[23:0]) * 48'(RECIP_255);
          neg   <= vprod[25];
          state <= ST_ACC;
        end
        ST_ACC: begin
          mix_acc <= mix_acc + scaled;
          if (new_phase >= end_fx) begin
            if (can_wrap) begin
              w_lp    <= ls;
              mod_div <= from_ls[PW-1:P];
              mod_d   <= w_len - ls;
              mod_rem <= 17'd0;
              mod_cnt <= 5'd17;
              state   <= ST_MOD;
            end else begin
              if (vidx == '0) begin
                music_active <= 1'b0;
                music_track  <= 16'd0;
              end else begin
                effect_valid[eidx] <= 1'b0;
              end
              vidx  <= vidx + VW'(1);
              state <= ST_VSEL;
            end
          end else begin
            if (vidx == '0) begin
              music_phase <= new_phase;
            end else begin
              effect_phase[eidx] <= new_phase;
            end
            vidx  <= vidx + VW'(1);
            state <= ST_VSEL;
          end
        end
        ST_MOD: begin
          mod_rem <= rem_next;
          mod_div <= {mod_div[15:0], 1'b0};
          mod_cnt <= mod_cnt - 5'd1;
          if (mod_cnt == 5'd1) begin
            if (vidx == '0) begin
              music_phase <= wrapped;
            end else begin
              effect_phase[eidx] <= wrapped;
            end
            vidx  <= vidx + VW'(1);
            state <= ST_VSEL;
          end
        end
        ST_SAT: begin
          res_valid <= 1'b1;
          if (mix_acc > 22'sd32767) begin
            res_sample <= 16'sh7fff;
          end else if (mix_acc < -22'sd32768) begin
            res_sample <= 16'sh8000;
          end else begin
            res_sample <= mix_acc[15:0];
          end
          res_play <= music_active && !music_paused;
          res_fx   <= |effect_valid;
          res_rej  <= 1'b0;
          state    <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- sim/tb_top.sv -----
// self-checking testbench of the sample clip voice mixer with a scoreboard class
module tb_top;
  import scvm_pkg::*;

  localparam logic [2:0]  OP_RSVD6  = 3'd6;
  localparam logic [2:0]  OP_RSVD7  = 3'd7;
  localparam logic [2:0]  ADDR_MUSIC_VOL  = 3'd0;
  localparam logic [2:0]  ADDR_EFFECT_VOL = 3'd4;
  localparam logic [15:0] WIN_BASE  = 16'hFFC0;
  localparam int          WIN_SIZE  = 128;
  localparam int          FRAC      = 16;
  localparam int          N_FX      = 4;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [15:0]        mem_addr;
    logic signed [15:0] sample_value;
    logic [15:0]        clip_start;
    logic [16:0]        clip_length;
    logic [15:0]        loop_start;
    logic [23:0]        phase_step;
    logic [15:0]        track_id;
    logic               loop_enable;
    logic               pause_music;
    logic               stop_music;
    logic               clear_effects;
  } mix_cmd_t;

  typedef struct packed {
    logic signed [15:0] mixed_sample;
    logic               music_playing;
    logic               effects_active;
    logic               start_rejected;
  } mix_res_t;

  class mixer_scoreboard;
    shortint         samples[65536];
    bit [7:0]        music_vol, effect_vol;
    bit              m_active, m_paused, m_looping, loop_opt;
    bit [15:0]       m_track, m_base;
    bit [16:0]       m_len, m_loop_pt;
    longint unsigned m_phase;
    bit [23:0]       m_inc;
    bit              fx_on[N_FX];
    bit [15:0]       fx_base[N_FX];
    bit [16:0]       fx_len[N_FX];
    longint unsigned fx_phase[N_FX];
    bit [23:0]       fx_inc[N_FX];
    mix_res_t        pending[$];
    int              errors, ticks, rejects, results;

    function void reset_state();
      music_vol = VOL_RESET;
      effect_vol = VOL_RESET;
      {m_active, m_paused, m_looping, loop_opt} = '0;
      m_track = 0; m_base = 0; m_len = 0; m_loop_pt = 0; m_phase = 0; m_inc = 0;
      foreach (fx_on[i]) begin
        fx_on[i] = 0; fx_base[i] = 0; fx_len[i] = 0; fx_phase[i] = 0; fx_inc[i] = 0;
      end
    endfunction

    function bit loop_ends(inout longint unsigned ph, input longint unsigned len,
                           input bit looping, input longint unsigned lp);
      longint unsigned ls, ls_fx, span_fx;
      if (!looping || len <= 1) return 1;
      ls = (lp < len - 1) ? lp : len - 1;
      if (ls >= len - 1) return 1;
      ls_fx = ls << FRAC;
      span_fx = (len - ls) << FRAC;
      ph = ls_fx + (ph - ls_fx) % span_fx;
      return 0;
    endfunction

    function longint play_voice(input bit [15:0] base, input longint unsigned len,
                                inout longint unsigned ph, input bit [23:0] inc,
                                input bit looping, input longint unsigned lp,
                                input bit [7:0] vol, output bit done);
      longint unsigned end_fx, idx, nxt;
      longint cur, nxt_s, frac, v;
      done = 0;
      if (len == 0) begin
        done = 1;
        return 0;
      end
      end_fx = len << FRAC;
      if (ph >= end_fx && loop_ends(ph, len, looping, lp)) begin
        done = 1;
        return 0;
      end
      idx = ph >> FRAC;
      if (idx > len - 1) idx = len - 1;
      nxt = (idx + 1 < len - 1) ? idx + 1 : len - 1;
      frac = longint'(ph - (idx << FRAC));
      cur = samples[16'(base + idx)];
      nxt_s = samples[16'(base + nxt)];
      v = cur + ((nxt_s - cur) * frac) / 65536;
      ph = ph + inc;
      if (ph >= end_fx) done = looping ? loop_ends(ph, len, looping, lp) : 1'b1;
      return (v * longint'(vol)) / 255;
    endfunction

    function void note_item(mix_cmd_t c);
      bit [16:0] len;
      longint    mix;
      bit        rej, done, any;
      mix_res_t  exp_item;
      mix = 0; rej = 0; any = 0;
      len = (c.clip_length > CLIP_MAX) ? CLIP_MAX : c.clip_length;
      case (c.opcode)
        OP_LOAD: samples[c.mem_addr] = c.sample_value;
        OP_MUSIC: begin
          if (m_active && m_track == c.track_id) m_paused = 0;
          else if (len == 0) rej = 1;
          else begin
            m_base = c.clip_start; m_len = len;
            m_loop_pt = (c.loop_start < len) ? 17'(c.loop_start) : len;
            m_looping = loop_opt; m_phase = 0; m_inc = c.phase_step;
            m_track = c.track_id; m_active = 1; m_paused = 0;
          end
        end
        OP_EFFECT: begin
          rej = 1;
          if (len != 0) begin
            for (int i = 0; i < N_FX; i++) begin
              if (rej && !fx_on[i]) begin
                fx_on[i] = 1; fx_base[i] = c.clip_start; fx_len[i] = len;
                fx_phase[i] = 0; fx_inc[i] = c.phase_step; rej = 0;
              end
            end
          end
        end
        OP_CTRL: begin
          m_paused = c.pause_music;
          if (c.stop_music) begin
            m_active = 0; m_track = 0;
          end
          if (c.clear_effects) foreach (fx_on[i]) fx_on[i] = 0;
        end
        OP_LOOP: begin
          loop_opt = c.loop_enable;
          if (m_active) m_looping = loop_opt;
        end
        OP_TICK: begin
          ticks++;
          if (m_active && !m_paused) begin
            mix += play_voice(m_base, m_len, m_phase, m_inc, m_looping, m_loop_pt,
                              music_vol, done);
            if (done) begin
              m_active = 0; m_track = 0;
            end
          end
          for (int i = 0; i < N_FX; i++) begin
            if (fx_on[i]) begin
              mix += play_voice(fx_base[i], fx_len[i], fx_phase[i], fx_inc[i], 0, 0,
                                effect_vol, done);
              if (done) fx_on[i] = 0;
            end
          end
          if (mix > 32767) mix = 32767;
          if (mix < -32768) mix = -32768;
        end
        default: ;
      endcase
      foreach (fx_on[i]) any |= fx_on[i];
      if (rej) rejects++;
      exp_item = '{16'(mix), m_active && !m_paused, any, rej};
      pending.insert(pending.size(), exp_item);
    endfunction

    function void check_result(mix_res_t r);
      mix_res_t e;
      results++;
      if (pending.size() == 0) begin
        $display("%0t unexpected result item %p", $time, r);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (e.mixed_sample !== r.mixed_sample) begin
        $display("%0t mixed_sample expected %0d actual %0d", $time, e.mixed_sample,
                 r.mixed_sample);
        errors++;
      end
      if (e.music_playing !== r.music_playing) begin
        $display("%0t music_playing expected %0b actual %0b", $time, e.music_playing,
                 r.music_playing);
        errors++;
      end
      if (e.effects_active !== r.effects_active) begin
        $display("%0t effects_active expected %0b actual %0b", $time, e.effects_active,
                 r.effects_active);
        errors++;
      end
      if (e.start_rejected !== r.start_rejected) begin
        $display("%0t start_rejected expected %0b actual %0b", $time, e.start_rejected,
                 r.start_rejected);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  int          send_idle_pct, recv_stall_pct;

  scvm_cmd_if cmd_ch();
  scvm_res_if res_ch();
  mixer_scoreboard sb;

  sample_clip_voice_mixer_top DUT (
    .clk(clk), .rst(rst), .cmd(cmd_ch), .res(res_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b0; #2;
    clk = 1'b1; #2;
  end

  always @(negedge clk) begin
    res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      sb.note_item('{cmd_ch.opcode, cmd_ch.mem_addr, cmd_ch.sample_value, cmd_ch.clip_start,
                     cmd_ch.clip_length, cmd_ch.loop_start, cmd_ch.phase_step,
                     cmd_ch.track_id, cmd_ch.loop_enable, cmd_ch.pause_music,
                     cmd_ch.stop_music, cmd_ch.clear_effects});
    end
    if (!rst && res_ch.valid && res_ch.ready) begin
      sb.check_result('{res_ch.mixed_sample, res_ch.music_playing, res_ch.effects_active,
                        res_ch.start_rejected});
    end
  end

  task automatic send_item(mix_cmd_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      cmd_ch.valid <= 1'b0;
    end
    @(negedge clk);
    {cmd_ch.opcode, cmd_ch.mem_addr, cmd_ch.sample_value, cmd_ch.clip_start,
     cmd_ch.clip_length, cmd_ch.loop_start, cmd_ch.phase_step, cmd_ch.track_id,
     cmd_ch.loop_enable, cmd_ch.pause_music, cmd_ch.stop_music,
     cmd_ch.clear_effects} <= c;
    cmd_ch.valid <= 1'b1;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_volume(logic [2:0] addr, logic [7:0] vol);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= {24'h0, vol};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_MUSIC_VOL) sb.music_vol = vol;
    else sb.effect_vol = vol;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  function automatic mix_cmd_t blank_cmd(logic [2:0] op);
    mix_cmd_t c;
    c = '0;
    c.opcode = op;
    return c;
  endfunction

  // clip inside the preloaded window; long clips only with a zero step
  function automatic mix_cmd_t clip_cmd(logic [2:0] op);
    mix_cmd_t c;
    int       ofs, kind;
    c = blank_cmd(op);
    kind = $urandom_range(0, 99);
    ofs = $urandom_range(0, WIN_SIZE - 2);
    c.clip_start = WIN_BASE + 16'(ofs);
    if (kind < 8) begin
      c.clip_length = 0;
      c.phase_step = $urandom;
    end else if (kind < 16) begin
      c.clip_length = $urandom_range(1, 131071);
      c.phase_step = 0;
    end else begin
      c.clip_length = $urandom_range(1, WIN_SIZE - ofs);
      c.phase_step = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 98304));
    end
    c.loop_start = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                   16'($urandom_range(0, int'(c.clip_length)));
    case ($urandom_range(0, 3))
      0: c.track_id = 16'h0105;
      1: c.track_id = 16'hFFFF;
      2: c.track_id = 16'h0000;
      default: c.track_id = $urandom;
    endcase
    return c;
  endfunction

  function automatic mix_cmd_t random_cmd();
    mix_cmd_t c;
    int       w;
    w = $urandom_range(0, 99);
    if (w < 45) c = blank_cmd(OP_TICK);
    else if (w < 58) begin
      c = blank_cmd(OP_LOAD);
      c.mem_addr = ($urandom_range(0, 1) == 0) ? 16'($urandom) :
                   WIN_BASE + 16'($urandom_range(0, WIN_SIZE - 1));
      c.sample_value = $urandom;
    end else if (w < 69) c = clip_cmd(OP_MUSIC);
    else if (w < 82) c = clip_cmd(OP_EFFECT);
    else if (w < 90) begin
      c = blank_cmd(OP_CTRL);
      c.pause_music = ($urandom_range(0, 3) == 0);
      c.stop_music = ($urandom_range(0, 2) == 0);
      c.clear_effects = ($urandom_range(0, 2) == 0);
    end else if (w < 97) begin
      c = blank_cmd(OP_LOOP);
      c.loop_enable = $urandom_range(0, 1);
    end else c = blank_cmd($urandom_range(0, 1) ? OP_RSVD6 : OP_RSVD7);
    return c;
  endfunction

  initial begin
    #8000000;
    $display("FAIL sample_clip_voice_mixer_top");
    $finish;
  end

  initial begin
    mix_cmd_t c;
    logic [7:0] mvols[4];
    logic [7:0] evols[4];
    int idle_s[4];
    int idle_r[4];

    mvols = '{8'd255, 8'd0, 8'd128, 8'd77};
    evols = '{8'd0, 8'd255, 8'd128, 8'd200};
    idle_s = '{0, 77, 0, 29};
    idle_r = '{0, 0, 77, 29};
    sb = new();
    sb.errors = 0; sb.ticks = 0; sb.rejects = 0; sb.results = 0;
    sb.reset_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    cmd_ch.valid = 1'b0;
    {cmd_ch.opcode, cmd_ch.mem_addr, cmd_ch.sample_value, cmd_ch.clip_start,
     cmd_ch.clip_length, cmd_ch.loop_start, cmd_ch.phase_step, cmd_ch.track_id,
     cmd_ch.loop_enable, cmd_ch.pause_music, cmd_ch.stop_music,
     cmd_ch.clear_effects} = '0;
    res_ch.ready = 1'b0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // fill the sample window, wrapping through the top of memory
    for (int i = 0; i < WIN_SIZE; i++) begin
      c = blank_cmd(OP_LOAD);
      c.mem_addr = WIN_BASE + 16'(i);
      c.sample_value = (i % 8 == 0) ? 16'sh7FFF : (i % 8 == 1) ? 16'sh8000 : 16'($urandom);
      send_item(c);
    end

    // directed part
    c = blank_cmd(OP_LOOP); c.loop_enable = 1; send_item(c);
    c = blank_cmd(OP_MUSIC); c.clip_start = WIN_BASE; c.clip_length = 6;
    c.loop_start = 2; c.phase_step = 24'h018000; c.track_id = 16'h0203; send_item(c);
    repeat (6) send_item(blank_cmd(OP_TICK));
    c = blank_cmd(OP_CTRL); c.pause_music = 1; send_item(c);
    send_item(blank_cmd(OP_TICK));
    c = blank_cmd(OP_MUSIC); c.track_id = 16'h0203; send_item(c);
    for (int i = 0; i < 5; i++) begin
      c = blank_cmd(OP_EFFECT); c.clip_start = WIN_BASE + 16'(8 * i);
      c.clip_length = (i == 0) ? 17'h1FFFF : 17'd8; c.phase_step = (i == 0) ? 24'h0 : 24'hFFFFFF;
      send_item(c);
    end
    send_item(blank_cmd(OP_TICK));
    c = blank_cmd(OP_EFFECT); send_item(c);
    c = blank_cmd(OP_MUSIC); c.track_id = 16'h0001; send_item(c);
    c = blank_cmd(OP_MUSIC); c.clip_start = 16'h0030; c.clip_length = 1;
    c.phase_step = 24'h000100; c.track_id = 16'hFFFF; send_item(c);
    send_item(blank_cmd(OP_TICK));
    send_item(blank_cmd(OP_RSVD6));
    send_item(blank_cmd(OP_RSVD7));
    c = blank_cmd(OP_CTRL); c.stop_music = 1; c.clear_effects = 1; send_item(c);
    send_item(blank_cmd(OP_TICK));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_volume(ADDR_MUSIC_VOL, mvols[ph]);
      write_volume(ADDR_EFFECT_VOL, evols[ph]);
      send_idle_pct = idle_s[ph];
      recv_stall_pct = idle_r[ph];
      for (int n = 0; n < 320; n++) begin
        if (ph == 1 && n == 160) drain();
        send_item(random_cmd());
      end
      drain();
    end

    repeat (200) @(posedge clk);
    $display("covered %0d result items, %0d ticks, %0d refused starts over four volume",
             sb.results, sb.ticks, sb.rejects);
    $display("and handshake pressure phases, with the sample window preloaded");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS sample_clip_voice_mixer_top");
    end else begin
      $display("FAIL sample_clip_voice_mixer_top");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/scvm_pkg.sv
rtl/core/scvm_if.sv
rtl/core/scvm_ram.sv
rtl/core/scvm_front.sv
rtl/core/scvm_back.sv
rtl/core/sample_clip_voice_mixer_top.sv
sim/tb_top.sv
